// ===== sv/ic_pkg.sv =====
package ic_pkg;

  localparam int IC_MAX_ELEMENTS = 256;
  localparam int IC_VALUE_WIDTH  = 32;

  localparam int              TOTAL_W   = 15;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  typedef struct packed {
    logic vld;
    logic last;
    logic ovf;
  } tok_ctl_t;

endpackage

// ===== sv/ic_cell.sv =====
module ic_cell
  import ic_pkg::*;
#(
  parameter int VALUE_WIDTH = IC_VALUE_WIDTH,
  parameter int IW          = 9,
  parameter int GW          = 8,
  parameter int IDX         = 0
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   adv,
  input  tok_ctl_t               ctl_i,
  input  logic [IW-1:0]          idx_i,
  input  logic [VALUE_WIDTH-1:0] val_i,
  input  logic [GW-1:0]          cnt_i,
  output tok_ctl_t               ctl_o,
  output logic [IW-1:0]          idx_o,
  output logic [VALUE_WIDTH-1:0] val_o,
  output logic [GW-1:0]          cnt_o
);

  tok_ctl_t               ctl_r;
  logic [IW-1:0]          idx_r;
  logic [VALUE_WIDTH-1:0] val_r;
  logic [GW-1:0]          cnt_r;
  logic [GW-1:0]          cnt_nxt;
  logic [VALUE_WIDTH-1:0] store_r;
  logic                   greater;
  logic                   wr_en;

  // count only against cells filled before this item entered
  assign greater = ctl_i.vld && !ctl_i.ovf && (idx_i > IW'(IDX)) &&
                   ($signed(store_r) > $signed(val_i));
  assign cnt_nxt = cnt_i + GW'(greater);
  assign wr_en   = adv && ctl_i.vld && !ctl_i.last && (idx_i == IW'(IDX));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (adv) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      idx_r <= idx_i;
      val_r <= val_i;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r <= val_i;
    end
  end

  assign ctl_o = ctl_r;
  assign idx_o = idx_r;
  assign val_o = val_r;
  assign cnt_o = cnt_r;

endmodule

// ===== sv/ic_accum.sv =====
module ic_accum
  import ic_pkg::*;
#(
  parameter int GW = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tok_ctl_t           exit_ctl,
  input  logic [GW-1:0]      exit_cnt,
  input  logic               out_tready,
  output logic               adv,
  output logic               out_tvalid,
  output logic [TOTAL_W-1:0] res_count,
  output logic               res_ovf
);

  localparam int SW = ((TOTAL_W > GW) ? TOTAL_W : GW) + 1;

  logic [TOTAL_W-1:0] total_r;
  logic [TOTAL_W-1:0] total_nxt;
  logic               ovf_r;
  logic               ovf_nxt;
  logic               valid_r;
  logic               valid_nxt;
  logic [SW-1:0]      sum;
  logic               take;
  logic               load;

  // stall only when a finished result is held and another final item arrives
  assign adv  = !(valid_r && !out_tready && exit_ctl.vld && exit_ctl.last);
  assign take = adv && exit_ctl.vld;
  assign load = take && exit_ctl.last;
  assign sum  = SW'(total_r) + SW'(exit_cnt);

  always_comb begin
    total_nxt = total_r;
    ovf_nxt   = ovf_r;
    if (take) begin
      total_nxt = (sum > SW'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOTAL_W-1:0];
      ovf_nxt   = ovf_r | exit_ctl.ovf;
    end
    valid_nxt = valid_r && !out_tready;
    if (load) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      ovf_r   <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (load) begin
        total_r <= '0;
        ovf_r   <= 1'b0;
      end else begin
        total_r <= total_nxt;
        ovf_r   <= ovf_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_count <= total_nxt;
      res_ovf   <= ovf_nxt;
    end
  end

  assign out_tvalid = valid_r;

endmodule

// ===== sv/inversion_counter.sv =====
// Counts inversions of a signed array streamed in one element per item, the
// final element marked by in_tlast. Each item walks a row of MAX_ELEMENTS
// cells, one cell per cycle while the row is not stalled, adding up the
// earlier elements it meets that are strictly greater, and drops its value
// into the first free cell. Items enter back to back at one per cycle; the
// result (count saturating at 32767, plus a flag for elements dropped beyond
// MAX_ELEMENTS) is registered in the accumulator once the final item has
// left the last cell of the row. The input stalls only while a result is held
// unread and the next final item reaches the end of the row.
module inversion_counter
  import ic_pkg::*;
#(
  parameter int MAX_ELEMENTS = IC_MAX_ELEMENTS,
  parameter int VALUE_WIDTH  = IC_VALUE_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [((VALUE_WIDTH+7)/8)*8-1:0]    in_tdata,   // value
  input  logic                                in_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [15:0]                         out_tdata,  // inversion_count, zero pad
  output logic                                out_tuser   // overflowed
);

  localparam int IW = $clog2(MAX_ELEMENTS + 1);
  localparam int GW = $clog2(MAX_ELEMENTS);

  tok_ctl_t               ctl_c [0:MAX_ELEMENTS];
  logic [IW-1:0]          idx_c [0:MAX_ELEMENTS];
  logic [VALUE_WIDTH-1:0] val_c [0:MAX_ELEMENTS];
  logic [GW-1:0]          cnt_c [0:MAX_ELEMENTS];

  logic               adv;
  logic               accept;
  logic [IW-1:0]      count_r;
  logic [IW-1:0]      count_nxt;
  logic               full;
  logic [TOTAL_W-1:0] res_count;

  assign in_tready = adv;
  assign accept    = in_tvalid && adv;
  assign full      = (count_r == IW'(MAX_ELEMENTS));

  always_comb begin
    count_nxt = count_r;
    if (accept) begin
      if (in_tlast) begin
        count_nxt = '0;
      end else if (!full) begin
        count_nxt = count_r + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign ctl_c[0].vld  = accept;
  assign ctl_c[0].last = in_tlast;
  assign ctl_c[0].ovf  = full;
  assign idx_c[0]      = count_r;
  assign val_c[0]      = in_tdata[VALUE_WIDTH-1:0];
  assign cnt_c[0]      = '0;

  for (genvar g = 0; g < MAX_ELEMENTS; g++) begin : g_cell
    ic_cell #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .IW          (IW),
      .GW          (GW),
      .IDX         (g)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .ctl_i (ctl_c[g]),
      .idx_i (idx_c[g]),
      .val_i (val_c[g]),
      .cnt_i (cnt_c[g]),
      .ctl_o (ctl_c[g+1]),
      .idx_o (idx_c[g+1]),
      .val_o (val_c[g+1]),
      .cnt_o (cnt_c[g+1])
    );
  end

  ic_accum #(
    .GW (GW)
  ) u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .exit_ctl   (ctl_c[MAX_ELEMENTS]),
    .exit_cnt   (cnt_c[MAX_ELEMENTS]),
    .out_tready (out_tready),
    .adv        (adv),
    .out_tvalid (out_tvalid),
    .res_count  (res_count),
    .res_ovf    (out_tuser)
  );

  assign out_tdata = {1'b0, res_count};

endmodule

// ===== sv/ic_checker.sv =====
module ic_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("item changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result shown after reset");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with no result pending");

endmodule

bind inversion_counter ic_checker u_ic_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
